[design/tgafp_pkg.sv]
// Shared types and constants for the TGA check, flip and premultiply block.
package tgafp_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int HDR_BYTES = 18;
  localparam int CNT_W     = 23;
  localparam int CFG_W     = 11;
  localparam int POS_W     = 10;
  localparam int NEED_W    = 24;
  localparam int COL_W     = $clog2(MAX_DIM);
  localparam int LIM_W     = COL_W + 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_TRUNC    = 4'd1,
    ST_ID       = 4'd2,
    ST_CMAP     = 4'd3,
    ST_RLE      = 4'd4,
    ST_TYPE     = 4'd5,
    ST_DESC     = 4'd6,
    ST_DIMS     = 4'd7,
    ST_DEPTH    = 4'd8,
    ST_LENGTH   = 4'd9
  } status_t;

  typedef struct packed {
    logic             is_status;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [7:0]       blue_out;
    logic [7:0]       green_out;
    logic [7:0]       red_out;
    logic [7:0]       alpha_out;
    status_t          status;
    logic             last;
  } result_t;

endpackage

[design/tga_check_flip_premultiply.sv]
// Top level: streaming TGA 32bpp checker and premultiplying pixel decoder.
//
// in_*  : one file byte per transfer, in_tlast on the final byte.
// out_* : results. A pixel result carries row (flipped bottom-up), column and
//         premultiplied B, G, R plus alpha; a status result (out_tuser = 1)
//         closes each file with out_tlast = 1 and the highest-priority header or
//         length error. Pixels go out before the status; drop them on a bad status.
// cfg_* : APB registers, expected_width at 0x0 and expected_height at 0x4.
//         Write them only between files.
// A result is registered in the result queue before it appears on out_*.
// Throughput: one byte per cycle; the result queue holds four entries and
// in_tready drops when fewer than two are free, so a final byte that yields
// both a pixel and a status still goes through in one transfer.
// A stalled receiver fills the queue and then backpressures the input.
// Reset clears the byte counter, header flags, row and column and empties the
// queue; the registers return to 1024 x 1024.
module tga_check_flip_premultiply (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // data_byte
  input  logic        in_tlast,    // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // out_row, out_col, blue, green, red, alpha, status
  output logic        out_tuser,   // is_status
  output logic        out_tlast,   // last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tgafp_pkg::*;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [CFG_W-1:0] exp_w_r, exp_h_r;
  logic             cfg_wr, fire;
  logic             pix_vld, sts_vld, room, head_vld;
  result_t          pix_res, sts_res, head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_w_r <= CFG_W'(MAX_DIM);
      exp_h_r <= CFG_W'(MAX_DIM);
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_WIDTH:  exp_w_r <= cfg_pwdata[CFG_W-1:0];
        REG_HEIGHT: exp_h_r <= cfg_pwdata[CFG_W-1:0];
        default:    exp_w_r <= exp_w_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_WIDTH:  cfg_prdata = 32'(exp_w_r);
      REG_HEIGHT: cfg_prdata = 32'(exp_h_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign in_tready = room;
  assign fire      = in_tvalid && in_tready;

  tgafp_decode u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .data_byte       (in_tdata),
    .end_of_file     (in_tlast),
    .expected_width  (exp_w_r),
    .expected_height (exp_h_r),
    .pix_vld         (pix_vld),
    .pix_res         (pix_res),
    .sts_vld         (sts_vld),
    .sts_res         (sts_res)
  );

  tgafp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix_vld  (pix_vld),
    .pix_res  (pix_res),
    .sts_vld  (sts_vld),
    .sts_res  (sts_res),
    .pop_rdy  (out_tready),
    .head_vld (head_vld),
    .head     (head),
    .room     (room)
  );

  assign out_tvalid = head_vld;
  assign out_tuser  = head.is_status;
  assign out_tlast  = head.last;
  assign out_tdata  = {head.status, head.alpha_out, head.red_out, head.green_out,
                       head.blue_out, head.out_col, head.out_row};

endmodule

[design/tgafp_decode.sv]
// Header checker, pixel assembler and premultiplier; one byte per cycle in which fire is high.
module tgafp_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_file,
  input  logic [tgafp_pkg::CFG_W-1:0] expected_width,
  input  logic [tgafp_pkg::CFG_W-1:0] expected_height,
  output logic                        pix_vld,
  output tgafp_pkg::result_t          pix_res,
  output logic                        sts_vld,
  output tgafp_pkg::result_t          sts_res
);
  import tgafp_pkg::*;

  localparam int F_ID     = 0;
  localparam int F_CMAP   = 1;
  localparam int F_RLE    = 2;
  localparam int F_TYPE   = 3;
  localparam int F_ORIGIN = 4;
  localparam int F_DEPTH  = 5;
  localparam int F_DESC   = 6;

  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] x;
    logic [16:0] s;
    x = {8'b0, c} * {8'b0, a} + 16'd127;
    // exact x/255 for x below 2^16
    s = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
    return s[15:8];
  endfunction

  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt, bc_upd;
  logic [6:0]        err_r, err_nxt, err_upd;
  logic [15:0]       seen_w_r, seen_w_nxt, sw_upd;
  logic [15:0]       seen_h_r, seen_h_nxt, sh_upd;
  logic [7:0]        held_r [0:2];
  logic [7:0]        held_nxt [0:2];
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CFG_W-1:0]  row_r, row_nxt;
  logic [NEED_W-1:0] need_r;
  logic [2*CFG_W-1:0] area;
  logic              hdr, body;
  logic [1:0]        phase;
  logic [LIM_W-1:0]  limit, col_inc;
  logic [CFG_W-1:0]  flip_row;
  status_t           sts;

  assign area = expected_width * expected_height;

  always_ff @(posedge clk) begin
    need_r <= NEED_W'(HDR_BYTES) + {area, 2'b00};
  end

  always_comb begin
    hdr     = byte_count_r < CNT_W'(HDR_BYTES);
    body    = !hdr && (byte_count_r != COUNT_MAX);
    phase   = byte_count_r[1:0] - 2'(HDR_BYTES % 4);
    bc_upd  = (byte_count_r != COUNT_MAX) ? byte_count_r + 1'b1 : byte_count_r;
    err_upd = err_r;
    sw_upd  = seen_w_r;
    sh_upd  = seen_h_r;
    if (hdr) begin
      case (byte_count_r[4:0])
        5'd0: begin
          if (data_byte != 8'd0) err_upd[F_ID] = 1'b1;
        end
        5'd1, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7: begin
          if (data_byte != 8'd0) err_upd[F_CMAP] = 1'b1;
        end
        5'd2: begin
          if (data_byte == TYPE_RLE) err_upd[F_RLE] = 1'b1;
          if (data_byte != TYPE_RAW) err_upd[F_TYPE] = 1'b1;
        end
        5'd8, 5'd9, 5'd10, 5'd11: begin
          if (data_byte != 8'd0) err_upd[F_ORIGIN] = 1'b1;
        end
        5'd12: sw_upd[7:0]  = data_byte;
        5'd13: sw_upd[15:8] = data_byte;
        5'd14: sh_upd[7:0]  = data_byte;
        5'd15: sh_upd[15:8] = data_byte;
        5'd16: begin
          if (data_byte != DEPTH_32) err_upd[F_DEPTH] = 1'b1;
        end
        default: begin
          if (data_byte != 8'd0) err_upd[F_DESC] = 1'b1;
        end
      endcase
    end

    limit = (expected_width == '0 || expected_width > CFG_W'(MAX_DIM))
            ? LIM_W'(MAX_DIM) : LIM_W'(expected_width);
    col_inc  = {1'b0, col_r} + 1'b1;
    flip_row = expected_height - 1'b1 - row_r;

    if (bc_upd < CNT_W'(HDR_BYTES))                    sts = ST_TRUNC;
    else if (err_upd[F_ID])                            sts = ST_ID;
    else if (err_upd[F_CMAP])                          sts = ST_CMAP;
    else if (err_upd[F_RLE])                           sts = ST_RLE;
    else if (err_upd[F_TYPE])                          sts = ST_TYPE;
    else if (err_upd[F_ORIGIN])                        sts = ST_DESC;
    else if (sw_upd != 16'(expected_width) ||
             sh_upd != 16'(expected_height))           sts = ST_DIMS;
    else if (err_upd[F_DEPTH])                         sts = ST_DEPTH;
    else if (err_upd[F_DESC])                          sts = ST_DESC;
    else if (NEED_W'(bc_upd) != need_r || bc_upd == COUNT_MAX) sts = ST_LENGTH;
    else                                               sts = ST_OK;

    pix_vld = fire && body && (phase == 2'd3);
    pix_res = '0;
    pix_res.out_row   = flip_row[POS_W-1:0];
    pix_res.out_col   = POS_W'(col_r);
    pix_res.blue_out  = premul(held_r[0], data_byte);
    pix_res.green_out = premul(held_r[1], data_byte);
    pix_res.red_out   = premul(held_r[2], data_byte);
    pix_res.alpha_out = data_byte;
    pix_res.status    = ST_OK;

    sts_vld = fire && end_of_file;
    sts_res = '0;
    sts_res.is_status = 1'b1;
    sts_res.status    = sts;
    sts_res.last      = 1'b1;

    byte_count_nxt = byte_count_r;
    err_nxt        = err_r;
    seen_w_nxt     = seen_w_r;
    seen_h_nxt     = seen_h_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    for (int i = 0; i < 3; i++) held_nxt[i] = held_r[i];

    if (fire) begin
      byte_count_nxt = bc_upd;
      err_nxt        = err_upd;
      seen_w_nxt     = sw_upd;
      seen_h_nxt     = sh_upd;
      if (body && phase != 2'd3) held_nxt[phase] = data_byte;
      if (pix_vld) begin
        if (col_inc >= limit) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_inc[COL_W-1:0];
        end
      end
      if (end_of_file) begin
        byte_count_nxt = '0;
        err_nxt        = '0;
        seen_w_nxt     = '0;
        seen_h_nxt     = '0;
        col_nxt        = '0;
        row_nxt        = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      err_r        <= '0;
      seen_w_r     <= '0;
      seen_h_r     <= '0;
      col_r        <= '0;
      row_r        <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      err_r        <= err_nxt;
      seen_w_r     <= seen_w_nxt;
      seen_h_r     <= seen_h_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) held_r[i] <= held_nxt[i];
  end

endmodule

[design/tgafp_outq.sv]
// Four-entry result queue; takes up to two results per cycle, head is the output.
module tgafp_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pix_vld,
  input  tgafp_pkg::result_t pix_res,
  input  logic               sts_vld,
  input  tgafp_pkg::result_t sts_res,
  input  logic               pop_rdy,
  output logic               head_vld,
  output tgafp_pkg::result_t head,
  output logic               room
);
  import tgafp_pkg::*;

  localparam int DEPTH = 4;

  result_t    q_r [0:DEPTH-1];
  result_t    q_nxt [0:DEPTH-1];
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] base, base1;
  logic       pop;
  result_t    item0;
  logic       push0, push1;

  assign head_vld = cnt_r != 3'd0;
  assign head     = q_r[0];
  assign room     = cnt_r <= 3'(DEPTH - 2);
  assign pop      = head_vld && pop_rdy;

  always_comb begin
    push0 = pix_vld || sts_vld;
    push1 = pix_vld && sts_vld;
    item0 = pix_vld ? pix_res : sts_res;
    base  = cnt_r - {2'b0, pop};
    base1 = base + 3'd1;
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && i < DEPTH - 1) q_nxt[i] = q_r[(i + 1) % DEPTH];
      else                      q_nxt[i] = q_r[i];
      if (push0 && base == 3'(i))  q_nxt[i] = item0;
      if (push1 && base1 == 3'(i)) q_nxt[i] = sts_res;
    end
    cnt_nxt = base + {2'b0, push0} + {2'b0, push1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) q_r[i] <= q_nxt[i];
  end

endmodule

[design/tgafp_check.sv]
// Port-level checker for the TGA decoder, bound to the top level.
module tgafp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == out_tuser)
    else $error("tlast does not match status kind");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[51:0] == 52'd0 && out_tdata[55:52] <= 4'd9)
    else $error("status transfer carries pixel bits or bad code");

  a_pixel_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[55:52] == 4'd0)
    else $error("pixel transfer carries a status code");

endmodule

bind tga_check_flip_premultiply tgafp_check u_tgafp_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
